// ===== src/pfpm_pkg.sv =====
// shared types and constants for the projective forward pixel map
package pfpm_pkg;

  localparam int unsigned OUT_WIDTH      = 448;
  localparam int unsigned OUT_HEIGHT     = 594;
  localparam int unsigned SRC_COORD_BITS = 12;

  localparam int unsigned COEF_W   = 48;
  localparam int unsigned NCOEF    = 8;
  localparam int unsigned CIDX_W   = 3;
  localparam int unsigned PROD_W   = COEF_W + SRC_COORD_BITS + 1;
  localparam int unsigned SUM_W    = PROD_W + 2;
  localparam int unsigned QBITS    = 12;
  localparam int unsigned DCMP_W   = SUM_W + QBITS;
  localparam int unsigned COL_W    = 9;
  localparam int unsigned ROW_W    = 10;

  localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(64'h1_0000_0000);

  typedef enum logic [CIDX_W-1:0] {
    REG_X_FROM_X = 3'd0,
    REG_X_FROM_Y = 3'd1,
    REG_X_OFFSET = 3'd2,
    REG_Y_FROM_X = 3'd3,
    REG_Y_FROM_Y = 3'd4,
    REG_Y_OFFSET = 3'd5,
    REG_W_FROM_X = 3'd6,
    REG_W_FROM_Y = 3'd7
  } coef_idx_e;

  typedef struct packed {
    logic [SRC_COORD_BITS-1:0] src_col;
    logic [SRC_COORD_BITS-1:0] src_row;
    logic [7:0]                in_blue;
    logic [7:0]                in_green;
    logic [7:0]                in_red;
  } src_pix_t;

  typedef struct packed {
    logic [COL_W-1:0] dst_col;
    logic [ROW_W-1:0] dst_row;
    logic [7:0]       out_blue;
    logic [7:0]       out_green;
    logic [7:0]       out_red;
  } dst_pix_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } color_t;

endpackage

// ===== src/pfpm_src_if.sv =====
// source pixel channel
interface pfpm_src_if;
  import pfpm_pkg::*;
  logic     valid;
  logic     ready;
  src_pix_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== src/pfpm_dst_if.sv =====
// frame-store write channel
interface pfpm_dst_if;
  import pfpm_pkg::*;
  logic     valid;
  logic     ready;
  dst_pix_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== src/projective_forward_pixel_map_top.sv =====
// projective forward pixel map: pipelined warp of source pixels to frame-store writes
// Maps each source pixel (col,row) through eight Q16.32 coefficients to
// |Nx/D|,|Ny/D| truncated, and emits a frame-store write when the target lies
// inside the 448x594 frame; a zero denominator or an outside target drops the
// pixel silently. One pixel is accepted per clock unless the output stalls.
// From input transaction to output register the pipe holds one stage of 48x13
// multipliers, one three-term add, one abs/zero-detect, one range compare, twelve
// restoring divide stages (one quotient bit each, column and row in parallel),
// and the output register with the frame check. The whole pipe advances together;
// it stalls only while the output register holds a transaction the sink has not
// taken. Coefficients are written through cfg_we_i/cfg_idx_i/cfg_data_i and
// should only change while the pipe is empty.
module projective_forward_pixel_map_top
  import pfpm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  pfpm_src_if.sink          pix_in,
  pfpm_dst_if.source        pix_out,
  input  logic              cfg_we_i,
  input  logic [CIDX_W-1:0] cfg_idx_i,
  input  logic [COEF_W-1:0] cfg_data_i
);

  typedef struct packed {
    logic              keep;
    logic [SUM_W-1:0]  rx;
    logic [SUM_W-1:0]  ry;
    logic [SUM_W-1:0]  dv;
    logic [QBITS-1:0]  qx;
    logic [QBITS-1:0]  qy;
    color_t            clr;
  } div_t;

  // coefficient registers
  logic [COEF_W-1:0] coef_q [NCOEF];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NCOEF; i++) begin
        coef_q[i] <= (i == REG_X_FROM_X || i == REG_Y_FROM_Y) ? COEF_ONE : '0;
      end
    end else if (cfg_we_i) begin
      coef_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // pipe advances unless the output register is stalled
  logic adv;
  logic out_vld_q;
  assign adv          = !out_vld_q || pix_out.ready;
  assign pix_in.ready = adv;

  // stage 1: products
  logic signed [PROD_W-1:0] prod_q [9];
  logic signed [PROD_W-1:0] prod_d [9];
  color_t                   s1_clr_q;
  logic                     s1_vld_q;
  logic signed [SRC_COORD_BITS:0] xs, ys, one_s;

  always_comb begin
    xs    = $signed({1'b0, pix_in.payload.src_col[SRC_COORD_BITS-1:0]});
    ys    = $signed({1'b0, pix_in.payload.src_row[SRC_COORD_BITS-1:0]});
    one_s = (SRC_COORD_BITS+1)'(1);
    prod_d[0] = $signed(coef_q[REG_X_FROM_X]) * xs;
    prod_d[1] = $signed(coef_q[REG_X_FROM_Y]) * ys;
    prod_d[2] = $signed(coef_q[REG_X_OFFSET]) * one_s;
    prod_d[3] = $signed(coef_q[REG_Y_FROM_X]) * xs;
    prod_d[4] = $signed(coef_q[REG_Y_FROM_Y]) * ys;
    prod_d[5] = $signed(coef_q[REG_Y_OFFSET]) * one_s;
    prod_d[6] = $signed(coef_q[REG_W_FROM_X]) * xs;
    prod_d[7] = $signed(coef_q[REG_W_FROM_Y]) * ys;
    prod_d[8] = $signed(COEF_ONE) * one_s;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod_q   <= prod_d;
      s1_clr_q <= '{pix_in.payload.in_blue, pix_in.payload.in_green, pix_in.payload.in_red};
    end
  end

  // stage 2: numerators and denominator
  logic signed [SUM_W-1:0] nx_q, ny_q, dn_q;
  color_t                  s2_clr_q;
  logic                    s2_vld_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      nx_q     <= SUM_W'(prod_q[0]) + SUM_W'(prod_q[1]) + SUM_W'(prod_q[2]);
      ny_q     <= SUM_W'(prod_q[3]) + SUM_W'(prod_q[4]) + SUM_W'(prod_q[5]);
      dn_q     <= SUM_W'(prod_q[6]) + SUM_W'(prod_q[7]) + SUM_W'(prod_q[8]);
      s2_clr_q <= s1_clr_q;
    end
  end

  // stage 3: magnitudes and zero denominator
  logic [SUM_W-1:0] ax_q, ay_q, ad_q;
  logic             s3_keep_q;
  color_t           s3_clr_q;
  logic             s3_vld_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ax_q      <= nx_q[SUM_W-1] ? SUM_W'(-nx_q) : nx_q;
      ay_q      <= ny_q[SUM_W-1] ? SUM_W'(-ny_q) : ny_q;
      ad_q      <= dn_q[SUM_W-1] ? SUM_W'(-dn_q) : dn_q;
      s3_keep_q <= (dn_q != '0);
      s3_clr_q  <= s2_clr_q;
    end
  end

  // stage 4: quotient range check, feeds divider
  div_t             dst_q [QBITS+1];
  logic             dvld_q [QBITS+1];
  logic [DCMP_W-1:0] dtop;

  assign dtop = {ad_q, {QBITS{1'b0}}};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dst_q[0].keep <= s3_keep_q && (DCMP_W'(ax_q) < dtop) && (DCMP_W'(ay_q) < dtop);
      dst_q[0].rx   <= ax_q;
      dst_q[0].ry   <= ay_q;
      dst_q[0].dv   <= ad_q;
      dst_q[0].qx   <= '0;
      dst_q[0].qy   <= '0;
      dst_q[0].clr  <= s3_clr_q;
    end
  end

  // restoring divide, one quotient bit per stage
  for (genvar i = 0; i < QBITS; i++) begin : g_div
    localparam int unsigned K = QBITS - 1 - i;
    logic [DCMP_W-1:0] sh;
    logic              gx, gy;
    div_t              dst_d;
    always_comb begin
      sh = DCMP_W'(dst_q[i].dv) << K;
      gx = DCMP_W'(dst_q[i].rx) >= sh;
      gy = DCMP_W'(dst_q[i].ry) >= sh;
      dst_d       = dst_q[i];
      dst_d.rx    = gx ? SUM_W'(DCMP_W'(dst_q[i].rx) - sh) : dst_q[i].rx;
      dst_d.ry    = gy ? SUM_W'(DCMP_W'(dst_q[i].ry) - sh) : dst_q[i].ry;
      dst_d.qx[K] = gx;
      dst_d.qy[K] = gy;
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        dst_q[i+1] <= dst_d;
      end
    end
  end

  // valid bits travel alongside the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      for (int i = 0; i <= QBITS; i++) begin
        dvld_q[i] <= 1'b0;
      end
      out_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q  <= pix_in.valid;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
      dvld_q[0] <= s3_vld_q;
      for (int i = 0; i < QBITS; i++) begin
        dvld_q[i+1] <= dvld_q[i];
      end
      // dropped pixels vanish here
      out_vld_q <= dvld_q[QBITS] && dst_q[QBITS].keep
                   && (dst_q[QBITS].qx < QBITS'(OUT_WIDTH))
                   && (dst_q[QBITS].qy < QBITS'(OUT_HEIGHT));
    end
  end

  // output register
  dst_pix_t out_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.dst_col   <= dst_q[QBITS].qx[COL_W-1:0];
      out_q.dst_row   <= dst_q[QBITS].qy[ROW_W-1:0];
      out_q.out_blue  <= dst_q[QBITS].clr.blue;
      out_q.out_green <= dst_q[QBITS].clr.green;
      out_q.out_red   <= dst_q[QBITS].clr.red;
    end
  end

  assign pix_out.valid   = out_vld_q;
  assign pix_out.payload = out_q;

endmodule

// ===== src/pfpm_checker.sv =====
// port-level checks for the projective forward pixel map
module pfpm_checker
  import pfpm_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_ready_i,
  input logic     out_valid_i,
  input logic     out_ready_i,
  input dst_pix_t out_payload_i
);

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output transaction dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_payload_i))
    else $error("output payload changed while stalled");

  a_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_payload_i.dst_col < COL_W'(OUT_WIDTH))
                    && (out_payload_i.dst_row < ROW_W'(OUT_HEIGHT)))
    else $error("write outside target frame");

  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("input taken while output stalled");

  a_free_flows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input blocked with empty output");

endmodule

bind projective_forward_pixel_map_top pfpm_checker u_pfpm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_i   (pix_in.ready),
  .out_valid_i  (pix_out.valid),
  .out_ready_i  (pix_out.ready),
  .out_payload_i(pix_out.payload)
);

// ===== test/pfpm_checker.sv =====
// checker: predicts frame-store writes from accepted source pixels and compares them
module pfpm_tb_checker
  import pfpm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  pfpm_src_if               pix_in,
  pfpm_dst_if               pix_out,
  input  logic              cfg_we_i,
  input  logic [CIDX_W-1:0] cfg_idx_i,
  input  logic [COEF_W-1:0] cfg_data_i,
  output int                fail_count_o,
  output int                pending_o
);

  logic signed [COEF_W-1:0] coef [NCOEF];
  dst_pix_t writes_due [$];
  int fail_count;

  assign pending_o    = writes_due.size();
  assign fail_count_o = fail_count;

  // exact projective map, one optional write
  function automatic bit map_pixel(input src_pix_t p, output dst_pix_t w);
    logic signed [127:0] x, y, nx, ny, den, q_col, q_row;
    x = 128'(p.src_col);
    y = 128'(p.src_row);
    nx = 128'(coef[REG_X_FROM_X]) * x + 128'(coef[REG_X_FROM_Y]) * y
         + 128'(coef[REG_X_OFFSET]);
    ny = 128'(coef[REG_Y_FROM_X]) * x + 128'(coef[REG_Y_FROM_Y]) * y
         + 128'(coef[REG_Y_OFFSET]);
    den = 128'(coef[REG_W_FROM_X]) * x + 128'(coef[REG_W_FROM_Y]) * y
          + 128'sh1_0000_0000;
    w = '0;
    if (den == 0) return 0;
    if (den < 0) den = -den;
    if (nx < 0) nx = -nx;
    if (ny < 0) ny = -ny;
    q_col = nx / den;
    q_row = ny / den;
    if (q_col >= OUT_WIDTH || q_row >= OUT_HEIGHT) return 0;
    w.dst_col = q_col[COL_W-1:0];
    w.dst_row = q_row[ROW_W-1:0];
    w.out_blue = p.in_blue;
    w.out_green = p.in_green;
    w.out_red = p.in_red;
    return 1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    dst_pix_t w, due;
    if (!rst_ni) begin
      foreach (coef[i])
        coef[i] <= (i == REG_X_FROM_X || i == REG_Y_FROM_Y) ? COEF_ONE : '0;
      fail_count <= 0;
      writes_due.delete();
    end else begin
      if (pix_out.valid && pix_out.ready) begin
        if (writes_due.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected write %p", pix_out.payload);
        end else begin
          due = writes_due.pop_front();
          if (due !== pix_out.payload) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("write mismatch: expected %p actual %p", due, pix_out.payload);
          end
        end
      end
      if (pix_in.valid && pix_in.ready && map_pixel(pix_in.payload, w))
        writes_due = {writes_due, w};
      if (cfg_we_i) coef[cfg_idx_i] <= cfg_data_i;
    end
  end

endmodule

// ===== test/tb_projective_forward_pixel_map_top.sv =====
// testbench top: drives pixels and coefficients, gives the verdict
module tb_projective_forward_pixel_map_top;
  import pfpm_pkg::*;

  localparam int PIPE_LAT = 17;
  localparam int STALL_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CIDX_W-1:0] cfg_idx_i = '0;
  logic [COEF_W-1:0] cfg_data_i = '0;
  int fail_count, pending;
  int src_idle_pct = 30, dst_idle_pct = 64;
  bit hold_sink = 1'b0;
  int quiet_cycles = 0;

  pfpm_src_if pix_in ();
  pfpm_dst_if pix_out ();

  always #6 clk_i = ~clk_i;

  initial begin
    pix_in.valid = 1'b0;
    pix_in.payload = '0;
    pix_out.ready = 1'b0;
  end

  projective_forward_pixel_map_top DUT (
    .clk_i, .rst_ni, .pix_in, .pix_out, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  pfpm_tb_checker u_checker (
    .clk_i, .rst_ni, .pix_in, .pix_out, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // receiver: random backpressure, or a long hold when asked
  always @(posedge clk_i)
    pix_out.ready <= !hold_sink && ($urandom_range(99) >= dst_idle_pct);

  // watchdog on cycles with no transaction on either side
  always @(posedge clk_i) begin
    if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("tb_projective_forward_pixel_map_top: done, errors");
      $finish;
    end
  end

  // offer one pixel until the transaction happens; valid stays up for the next one
  task automatic send_pixel(input src_pix_t p);
    while ($urandom_range(99) < src_idle_pct) begin
      pix_in.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_in.valid <= 1'b1;
    pix_in.payload <= p;
    @(posedge clk_i);
    while (!pix_in.ready) @(posedge clk_i);
  endtask

  task automatic stop_input();
    pix_in.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain_pipe();
    stop_input();
    while (pending != 0) @(posedge clk_i);
    repeat (PIPE_LAT + 4) @(posedge clk_i);
  endtask

  // write enable stays up for back-to-back writes, dropped by load_setting
  task automatic write_coef(input coef_idx_e idx, input logic [COEF_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
  endtask

  function automatic src_pix_t rand_pixel(input int max_coord);
    src_pix_t p;
    p.src_col = SRC_COORD_BITS'($urandom_range(max_coord));
    p.src_row = SRC_COORD_BITS'($urandom_range(max_coord));
    p.in_blue = 8'($urandom);
    p.in_green = 8'($urandom);
    p.in_red = 8'($urandom);
    return p;
  endfunction

  // q16.32 value from a signed integer part and random fraction bits
  function automatic logic [COEF_W-1:0] q32(input int ipart, input int frac_bits);
    logic signed [COEF_W-1:0] v;
    v = (COEF_W'(signed'(ipart)) <<< 32);
    if (frac_bits > 0)
      v = v + (COEF_W'($urandom_range((1 << frac_bits) - 1)) << (32 - frac_bits));
    return v;
  endfunction

  // one setting of all eight coefficients, of a given flavor
  task automatic load_setting(input int kind);
    case (kind)
      0: begin
        // identity
        write_coef(REG_X_FROM_X, COEF_ONE); write_coef(REG_X_FROM_Y, '0);
        write_coef(REG_X_OFFSET, '0);       write_coef(REG_Y_FROM_X, '0);
        write_coef(REG_Y_FROM_Y, COEF_ONE); write_coef(REG_Y_OFFSET, '0);
        write_coef(REG_W_FROM_X, '0);       write_coef(REG_W_FROM_Y, '0);
      end
      1: begin
        // mild perspective with scale between zero and two, mirrored signs possible
        write_coef(REG_X_FROM_X, q32(0, 0) + COEF_W'($urandom) * 2);
        write_coef(REG_X_FROM_Y, COEF_W'(signed'($urandom_range(0, 1 << 28)))
                                 - COEF_W'(1 << 27));
        write_coef(REG_X_OFFSET, q32($urandom_range(0, 200) - 100, 16));
        write_coef(REG_Y_FROM_X, COEF_W'(signed'($urandom_range(0, 1 << 28)))
                                 - COEF_W'(1 << 27));
        write_coef(REG_Y_FROM_Y, q32(0, 0) + COEF_W'($urandom) * 2);
        write_coef(REG_Y_OFFSET, q32($urandom_range(0, 200) - 100, 16));
        write_coef(REG_W_FROM_X, COEF_W'(signed'($urandom_range(0, 1 << 22)))
                                 - COEF_W'(1 << 21));
        write_coef(REG_W_FROM_Y, COEF_W'(signed'($urandom_range(0, 1 << 22)))
                                 - COEF_W'(1 << 21));
      end
      2: begin
        // extremes: most negative and most positive coefficients
        write_coef(REG_X_FROM_X, {1'b1, {(COEF_W-1){1'b0}}});
        write_coef(REG_X_FROM_Y, {1'b0, {(COEF_W-1){1'b1}}});
        write_coef(REG_X_OFFSET, {1'b1, {(COEF_W-1){1'b0}}});
        write_coef(REG_Y_FROM_X, {1'b0, {(COEF_W-1){1'b1}}});
        write_coef(REG_Y_FROM_Y, {1'b1, {(COEF_W-1){1'b0}}});
        write_coef(REG_Y_OFFSET, {1'b0, {(COEF_W-1){1'b1}}});
        write_coef(REG_W_FROM_X, {1'b0, {(COEF_W-1){1'b1}}});
        write_coef(REG_W_FROM_Y, {1'b1, {(COEF_W-1){1'b0}}});
      end
      3: begin
        // denominator hits zero on the line x + y = 64; negative numerators
        write_coef(REG_X_FROM_X, q32(-1, 8)); write_coef(REG_X_FROM_Y, q32(0, 8));
        write_coef(REG_X_OFFSET, '0);          write_coef(REG_Y_FROM_X, q32(0, 8));
        write_coef(REG_Y_FROM_Y, q32(-1, 0)); write_coef(REG_Y_OFFSET, q32(5, 0));
        write_coef(REG_W_FROM_X, COEF_W'(-(64'sd1 <<< 26)));
        write_coef(REG_W_FROM_Y, COEF_W'(-(64'sd1 <<< 26)));
      end
      default: begin
        // fully random bits
        for (int i = 0; i < NCOEF; i++)
          write_coef(coef_idx_e'(i), {$urandom, $urandom} & {COEF_W{1'b1}});
      end
    endcase
    cfg_we_i <= 1'b0;
  endtask

  // long receiver hold while the sender keeps offering
  initial begin
    wait (rst_ni);
    repeat (600) @(posedge clk_i);
    hold_sink = 1'b1;
    repeat (200) @(posedge clk_i);
    hold_sink = 1'b0;
  end

  initial begin
    src_pix_t p;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: field extremes under identity, frame edges, drop cases
    p = '0; send_pixel(p);
    p = '1; send_pixel(p);
    p = '{src_col: 447, src_row: 593, in_blue: 8'hff, in_green: 8'h00, in_red: 8'haa};
    send_pixel(p);
    p = '{src_col: 448, src_row: 10, in_blue: 1, in_green: 2, in_red: 3}; send_pixel(p);
    p = '{src_col: 10, src_row: 594, in_blue: 4, in_green: 5, in_red: 6}; send_pixel(p);
    p = '{src_col: 12'haaa, src_row: 12'h555, in_blue: 8'h55, in_green: 8'haa,
          in_red: 8'h0f};
    send_pixel(p);
    drain_pipe();
    load_setting(3);
    for (int i = 0; i < 8; i++) begin
      // points on and near the zero-denominator line
      p = rand_pixel(0);
      p.src_col = SRC_COORD_BITS'(20 + i);
      p.src_row = SRC_COORD_BITS'(44 - i + (i % 3) - 1);
      send_pixel(p);
    end
    drain_pipe();
    load_setting(2);
    p = '1; send_pixel(p);
    p = '0; send_pixel(p);
    p = rand_pixel(4095); send_pixel(p);
    drain_pipe();

    // random phases: sender/receiver idling swaps, then full rate
    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct = (ph == 0) ? 30 : (ph == 1) ? 64 : 0;
      dst_idle_pct = (ph == 0) ? 64 : (ph == 1) ? 30 : 0;
      for (int s = 0; s < 5; s++) begin
        load_setting((s == 4) ? 4 : (s == 0) ? 0 : (s == 3) ? 3 : 1);
        for (int i = 0; i < 62; i++) begin
          p = rand_pixel(($urandom_range(3) == 0) ? 4095 : 700);
          send_pixel(p);
          // occasional full pause until every write has come
          if (i == 31 && s == 2) begin
            stop_input();
            while (pending != 0) @(posedge clk_i);
          end
        end
        drain_pipe();
      end
    end

    while (pending != 0) @(posedge clk_i);
    repeat (PIPE_LAT + 10) @(posedge clk_i);
    if (fail_count == 0)
      $display("tb_projective_forward_pixel_map_top: done, clean");
    else
      $display("tb_projective_forward_pixel_map_top: done, errors");
    $finish;
  end

endmodule
